[hdl/ansi_text_console_writer_assert.svh]
// Assertion macros used by the console writer executor.
`ifndef ANSI_TEXT_CONSOLE_WRITER_ASSERT_SVH
`define ANSI_TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ATCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("console writer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ATCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("console writer check failed");

`endif

[hdl/atcw_pkg.sv]
// Types, codes and constants of the ANSI text console writer.
package atcw_pkg;

  localparam logic [7:0] KEY_ESC = 8'h1B;
  localparam logic [7:0] KEY_CSI = 8'h5B;
  localparam logic [7:0] KEY_CR = 8'h0D;
  localparam logic [7:0] KEY_LF = 8'h0A;
  localparam logic [7:0] KEY_BS = 8'h08;
  localparam logic [7:0] KEY_TAB = 8'h09;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [9:0] PARAM_MAX = 10'd999;
  localparam logic [3:0] LIGHT_BIT = 4'h8;
  localparam logic [3:0] FG_DEFAULT = 4'd7;
  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [5:0] ROWS_RESET = 6'd25;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Register indexes on the configuration port.
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_CELL, ACT_SCROLL, ACT_CLEAR, ACT_ERASE
  } act_t;

  typedef enum logic [1:0] {
    PM_TEXT, PM_ESC, PM_CSI
  } parse_mode_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_GLYPH, OP_CR, OP_LF, OP_BS, OP_TAB, OP_UP, OP_DOWN, OP_RIGHT,
    OP_LEFT, OP_HOME, OP_CLEAR, OP_ERASE, OP_SAVE, OP_RESTORE
  } op_kind_t;

  // One classified byte handed from the parser to the executor.
  typedef struct packed {
    op_kind_t   kind;
    logic       esc_pre;
    logic [7:0] ch;
    logic [9:0] p_cur;
    logic [9:0] p_prev;
    logic [3:0] fg;
    logic [3:0] bg;
  } op_t;

endpackage

[hdl/atcw_in_if.sv]
// Input byte channel of the console writer.
interface atcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_of_write;

  modport source (output valid, char_code, last_of_write, input ready);
  modport sink (input valid, char_code, last_of_write, output ready);
endinterface

[hdl/atcw_out_if.sv]
// Result channel of the console writer towards the display memory engine.
interface atcw_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] cell_col;
  logic [5:0] cell_row;
  logic [7:0] cell_char;
  logic [3:0] cell_fg;
  logic [3:0] cell_bg;
  logic [7:0] cursor_col_out;
  logic [5:0] cursor_row_out;
  logic       last;

  modport source (output valid, action, cell_col, cell_row, cell_char, cell_fg, cell_bg,
                  cursor_col_out, cursor_row_out, last, input ready);
  modport sink (input valid, action, cell_col, cell_row, cell_char, cell_fg, cell_bg,
                cursor_col_out, cursor_row_out, last, output ready);
endinterface

[hdl/atcw_front.sv]
// Escape parser: accepts bytes, tracks parameters and colours, classifies each byte.
module atcw_front import atcw_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  atcw_in_if.sink in_ch,
  input  logic   op_ready,
  output logic   op_valid,
  output op_t    op
);

  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
  } colors_t;

  parse_mode_t mode_r, mode_nxt;
  logic [9:0]  pc_r, pc_nxt, pp_r, pp_nxt;
  logic [3:0]  fg_r, fg_nxt, bg_r, bg_nxt;
  logic        accept;
  logic [7:0]  b;
  logic [13:0] digit_sum;
  colors_t     c_cur, c_mid, c_end;

  // Applies one colour parameter to a colour pair.
  function automatic colors_t apply_color(input logic [9:0] n, input colors_t c);
    colors_t r;
    logic [9:0] d;
    r = c;
    d = 10'd0;
    if (n == 10'd0) begin
      r.fg = FG_DEFAULT;
    end else if (n == 10'd1) begin
      r.fg = c.fg | LIGHT_BIT;
    end else if (n == 10'd2) begin
      r.bg = c.bg | LIGHT_BIT;
    end else if (n == 10'd7) begin
      r.fg = c.bg;
      r.bg = c.fg;
    end else if (n == 10'd8) begin
      r.fg = 4'd0;
      r.bg = 4'd0;
    end else if (n >= 10'd30 && n < 10'd38) begin
      d = n - 10'd30;
      r.fg = {c.fg[3], d[2:0]};
    end else if (n >= 10'd40 && n < 10'd48) begin
      d = n - 10'd40;
      r.bg = {c.bg[3], d[2:0]};
    end
    return r;
  endfunction

  // Kind of a byte met in plain text.
  function automatic op_kind_t text_kind(input logic [7:0] ch);
    op_kind_t k;
    if (ch == KEY_ESC) k = OP_NONE;
    else if (ch == KEY_CR) k = OP_CR;
    else if (ch == KEY_LF) k = OP_LF;
    else if (ch == KEY_BS) k = OP_BS;
    else if (ch == KEY_TAB) k = OP_TAB;
    else k = OP_GLYPH;
    return k;
  endfunction

  assign in_ch.ready = op_ready;
  assign accept = in_ch.valid && op_ready;
  assign op_valid = in_ch.valid;
  assign b = in_ch.char_code;

  assign digit_sum = {1'b0, pc_r, 3'b000} + {3'b000, pc_r, 1'b0} + {10'd0, b[3:0]};
  assign c_cur = '{fg: fg_r, bg: bg_r};
  assign c_mid = (pp_r != 10'd0) ? apply_color(pp_r, c_cur) : c_cur;
  assign c_end = apply_color(pc_r, c_mid);

  // Classification and next parser state.
  always_comb begin
    op = '{kind: OP_NONE, esc_pre: 1'b0, ch: b, p_cur: pc_r, p_prev: pp_r,
           fg: fg_r, bg: bg_r};
    mode_nxt = mode_r;
    pc_nxt = pc_r;
    pp_nxt = pp_r;
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    unique case (mode_r)
      PM_ESC: begin
        if (b == KEY_CSI) begin
          mode_nxt = PM_CSI;
          pc_nxt = 10'd0;
          pp_nxt = 10'd0;
        end else begin
          op.esc_pre = 1'b1;
          op.kind = text_kind(b);
          mode_nxt = (b == KEY_ESC) ? PM_ESC : PM_TEXT;
        end
      end
      PM_CSI: begin
        if (b >= 8'h30 && b <= 8'h39) begin
          pc_nxt = (digit_sum > {4'd0, PARAM_MAX}) ? PARAM_MAX : digit_sum[9:0];
        end else if (b == 8'h3B) begin
          pp_nxt = pc_r;
          pc_nxt = 10'd0;
        end else begin
          mode_nxt = PM_TEXT;
          unique case (b)
            8'h6D: begin
              fg_nxt = c_end.fg;
              bg_nxt = c_end.bg;
            end
            8'h41: op.kind = OP_UP;
            8'h42: op.kind = OP_DOWN;
            8'h43: op.kind = OP_RIGHT;
            8'h44: op.kind = OP_LEFT;
            8'h48: op.kind = OP_HOME;
            8'h4A: op.kind = OP_CLEAR;
            8'h4B: op.kind = OP_ERASE;
            8'h73: op.kind = OP_SAVE;
            8'h75: op.kind = OP_RESTORE;
            default: op.kind = OP_NONE;
          endcase
        end
      end
      default: begin
        op.kind = text_kind(b);
        mode_nxt = (b == KEY_ESC) ? PM_ESC : PM_TEXT;
      end
    endcase
    if (in_ch.last_of_write) mode_nxt = PM_TEXT;
  end

  // Parser registers advance on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= PM_TEXT;
      pc_r <= 10'd0;
      pp_r <= 10'd0;
      fg_r <= FG_DEFAULT;
      bg_r <= 4'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pc_r <= pc_nxt;
      pp_r <= pp_nxt;
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
    end
  end

endmodule

[hdl/atcw_queue.sv]
// Small queue of classified bytes between the parser and the executor.
module atcw_queue import atcw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  input  logic pop,
  output op_t  pop_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  op_t           slots [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = slots[rd_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_r] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == LAST_IDX) ? '0 : wr_r + 1'b1;
      if (do_pop) rd_r <= (rd_r == LAST_IDX) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[hdl/atcw_back.sv]
// Executor: owns the cursor and issues at most one display command per cycle, holding while the output is stalled.
module atcw_back import atcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] cols,
  input  logic [5:0] rows,
  input  op_t        op,
  input  logic       op_avail,
  output logic       op_pop,
  atcw_out_if.source out_ch
);

  op_t        op_r, op_nxt;
  logic       have_r, have_nxt, esc_r, esc_nxt, scr_r, scr_nxt, main_r, main_nxt;
  logic [7:0] col_r, col_nxt, scol_r, scol_nxt;
  logic [5:0] row_r, row_nxt, srow_r, srow_nxt;
  logic       ov_r, ov_nxt;
  act_t       act_r, act_nxt;
  logic [7:0] ccol_r, ccol_nxt, cchar_r, cchar_nxt;
  logic [5:0] crow_r, crow_nxt;
  logic [3:0] cfg_r, cfg_nxt, cbg_r, cbg_nxt;
  logic       last_r, last_nxt;
  logic       emit, fin;
  logic [7:0] col_max;
  logic [5:0] row_max;
  logic [8:0] g_col1;
  logic       g_wrap, g_scroll;
  logic [6:0] g_row1;
  logic [7:0] g_col;
  logic [5:0] g_row;
  logic [9:0] n1;
  logic [10:0] row_sum, col_sum;

  assign col_max = cols - 8'd1;
  assign row_max = rows - 6'd1;
  assign emit = have_r && (!ov_r || out_ch.ready);
  assign op_pop = !have_r && op_avail;

  // Cursor after one glyph: advance, wrap, and hold on the last row.
  assign g_col1 = {1'b0, col_r} + 9'd1;
  assign g_wrap = g_col1 >= {1'b0, cols};
  assign g_col = g_wrap ? 8'd0 : g_col1[7:0];
  assign g_row1 = g_wrap ? {1'b0, row_r} + 7'd1 : {1'b0, row_r};
  assign g_scroll = g_row1 >= {1'b0, rows};
  assign g_row = g_scroll ? row_max : g_row1[5:0];

  assign n1 = (op_r.p_cur == 10'd0) ? 10'd1 : op_r.p_cur;
  assign row_sum = {5'd0, row_r} + {1'b0, n1};
  assign col_sum = {3'd0, col_r} + {1'b0, n1};

  // Sequencing of the results of one byte.
  always_comb begin
    op_nxt = op_r;
    have_nxt = have_r;
    esc_nxt = esc_r;
    scr_nxt = scr_r;
    main_nxt = main_r;
    col_nxt = col_r;
    row_nxt = row_r;
    scol_nxt = scol_r;
    srow_nxt = srow_r;
    ov_nxt = ov_r && !out_ch.ready;
    act_nxt = act_r;
    ccol_nxt = ccol_r;
    crow_nxt = crow_r;
    cchar_nxt = cchar_r;
    cfg_nxt = cfg_r;
    cbg_nxt = cbg_r;
    last_nxt = last_r;
    fin = 1'b0;
    if (op_pop) begin
      op_nxt = op;
      have_nxt = 1'b1;
      esc_nxt = op.esc_pre;
      scr_nxt = 1'b0;
      main_nxt = 1'b0;
    end else if (!have_r) begin
      // Keep both positions inside the screen after a geometry change.
      if (col_r > col_max) col_nxt = col_max;
      if (scol_r > col_max) scol_nxt = col_max;
      if (row_r > row_max) row_nxt = row_max;
      if (srow_r > row_max) srow_nxt = row_max;
    end
    if (emit) begin
      ov_nxt = 1'b1;
      act_nxt = ACT_NONE;
      ccol_nxt = 8'd0;
      crow_nxt = 6'd0;
      cchar_nxt = 8'd0;
      cfg_nxt = 4'd0;
      cbg_nxt = 4'd0;
      if (scr_r) begin
        act_nxt = ACT_SCROLL;
        cchar_nxt = KEY_SPACE;
        cfg_nxt = op_r.fg;
        cbg_nxt = op_r.bg;
        scr_nxt = 1'b0;
        fin = main_r;
      end else if (esc_r) begin
        act_nxt = ACT_CELL;
        ccol_nxt = col_r;
        crow_nxt = row_r;
        cchar_nxt = KEY_ESC;
        cfg_nxt = op_r.fg;
        cbg_nxt = op_r.bg;
        col_nxt = g_col;
        row_nxt = g_row;
        scr_nxt = g_scroll;
        esc_nxt = 1'b0;
      end else begin
        main_nxt = 1'b1;
        unique case (op_r.kind)
          OP_GLYPH, OP_TAB: begin
            act_nxt = ACT_CELL;
            ccol_nxt = col_r;
            crow_nxt = row_r;
            cchar_nxt = (op_r.kind == OP_TAB) ? KEY_SPACE : op_r.ch;
            cfg_nxt = op_r.fg;
            cbg_nxt = op_r.bg;
            col_nxt = g_col;
            row_nxt = g_row;
            scr_nxt = g_scroll;
            if (op_r.kind == OP_TAB && g_col[1:0] != 2'd0) main_nxt = 1'b0;
          end
          OP_CR: col_nxt = 8'd0;
          OP_LF: begin
            col_nxt = 8'd0;
            if ({1'b0, row_r} + 7'd1 >= {1'b0, rows}) begin
              row_nxt = row_max;
              act_nxt = ACT_SCROLL;
              cchar_nxt = KEY_SPACE;
              cfg_nxt = op_r.fg;
              cbg_nxt = op_r.bg;
            end else begin
              row_nxt = row_r + 6'd1;
            end
          end
          OP_BS: begin
            col_nxt = (col_r == 8'd0) ? col_max : col_r - 8'd1;
            act_nxt = ACT_CELL;
            ccol_nxt = col_nxt;
            crow_nxt = row_r;
            cchar_nxt = KEY_SPACE;
            cfg_nxt = op_r.fg;
            cbg_nxt = op_r.bg;
          end
          OP_UP: row_nxt = (n1 > {4'd0, row_r}) ? 6'd0 : row_r - n1[5:0];
          OP_DOWN: row_nxt = (row_sum > {5'd0, row_max}) ? row_max : row_sum[5:0];
          OP_RIGHT: col_nxt = (col_sum > {3'd0, col_max}) ? col_max : col_sum[7:0];
          OP_LEFT: col_nxt = (n1 > {2'd0, col_r}) ? 8'd0 : col_r - n1[7:0];
          OP_HOME: begin
            col_nxt = (op_r.p_cur > {2'd0, col_max}) ? col_max : op_r.p_cur[7:0];
            row_nxt = (op_r.p_prev > {4'd0, row_max}) ? row_max : op_r.p_prev[5:0];
          end
          OP_CLEAR: begin
            col_nxt = 8'd0;
            row_nxt = 6'd0;
            act_nxt = ACT_CLEAR;
            cchar_nxt = KEY_SPACE;
            cfg_nxt = op_r.fg;
            cbg_nxt = op_r.bg;
          end
          OP_ERASE: begin
            act_nxt = ACT_ERASE;
            ccol_nxt = col_r;
            crow_nxt = row_r;
            cchar_nxt = KEY_SPACE;
            cfg_nxt = op_r.fg;
            cbg_nxt = op_r.bg;
          end
          OP_SAVE: begin
            scol_nxt = col_r;
            srow_nxt = row_r;
          end
          OP_RESTORE: begin
            col_nxt = scol_r;
            row_nxt = srow_r;
          end
          default: ;
        endcase
        fin = main_nxt && !scr_nxt;
      end
      last_nxt = fin;
      if (fin) have_nxt = 1'b0;
    end
  end

  // Control and cursor registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      esc_r <= 1'b0;
      scr_r <= 1'b0;
      main_r <= 1'b0;
      ov_r <= 1'b0;
      col_r <= 8'd0;
      row_r <= 6'd0;
      scol_r <= 8'd0;
      srow_r <= 6'd0;
    end else begin
      have_r <= have_nxt;
      esc_r <= esc_nxt;
      scr_r <= scr_nxt;
      main_r <= main_nxt;
      ov_r <= ov_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      scol_r <= scol_nxt;
      srow_r <= srow_nxt;
    end
  end

  // Current byte and output payload.
  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    act_r <= act_nxt;
    ccol_r <= ccol_nxt;
    crow_r <= crow_nxt;
    cchar_r <= cchar_nxt;
    cfg_r <= cfg_nxt;
    cbg_r <= cbg_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.action = act_r;
  assign out_ch.cell_col = ccol_r;
  assign out_ch.cell_row = crow_r;
  assign out_ch.cell_char = cchar_r;
  assign out_ch.cell_fg = cfg_r;
  assign out_ch.cell_bg = cbg_r;
  assign out_ch.cursor_col_out = col_r;
  assign out_ch.cursor_row_out = row_r;
  assign out_ch.last = last_r;

`include "ansi_text_console_writer_assert.svh"

  `ATCW_ASSERT_NOW(a_scroll_on_bottom, ov_r && act_r == ACT_SCROLL, row_r == row_max)
  `ATCW_ASSERT_NOW(a_none_is_blank, ov_r && act_r == ACT_NONE, ccol_r == 8'd0 && cchar_r == 8'd0)
  `ATCW_ASSERT_NOW(a_no_load_when_busy, op_pop, !have_r)
  `ATCW_ASSERT_NEXT(a_last_frees, emit && fin, !have_r)

endmodule

[hdl/ansi_text_console_writer.sv]
// Top level of the ANSI text console writer: configuration port and the three parts.
//
//   channel | direction | handshake           | transaction
//   in_ch   | in        | valid/ready         | one console byte
//   out_ch  | out       | valid/ready         | one display command
//   cfg     | in        | APB, pready tied hi | one register access
//
// A byte is classified in the cycle it is accepted and pushed into the queue. The executor
// loads it into its byte register, issues its results (1 to 7) in turn, and takes the next
// byte only once the last is out; each result is held in the executor's output registers.
// The executor's one-result-per-cycle sequencer, while out_ch is not stalled, sets the rate;
// a tab after a stray ESC that wraps and scrolls twice is the longest.
// Reset is synchronous and active low; cursor 0,0, colours 7 on 0, 80 by 25.
// A stalled output holds the executor; the parser runs on while the queue has room.
module ansi_text_console_writer import atcw_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  atcw_in_if.sink     in_ch,
  atcw_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] cols_r;
  logic [5:0] rows_r;
  logic       wr;
  op_t        f_op, q_op;
  logic       f_valid, q_full, q_empty, q_pop;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_ROWS) ? {26'd0, rows_r} : {24'd0, cols_r};

  // Geometry registers; values below two are raised to two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLUMNS_RESET;
      rows_r <= ROWS_RESET;
    end else if (wr) begin
      if (cfg_paddr[2] == REG_COLUMNS) begin
        cols_r <= (cfg_pwdata[7:0] < 8'd2) ? 8'd2 : cfg_pwdata[7:0];
      end else begin
        rows_r <= (cfg_pwdata[5:0] < 6'd2) ? 6'd2 : cfg_pwdata[5:0];
      end
    end
  end

  atcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .op_ready (!q_full),
    .op_valid (f_valid),
    .op       (f_op)
  );

  atcw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data (f_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_op),
    .empty     (q_empty)
  );

  atcw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cols     (cols_r),
    .rows     (rows_r),
    .op       (q_op),
    .op_avail (!q_empty),
    .op_pop   (q_pop),
    .out_ch   (out_ch)
  );

endmodule
